FILE: hw/rtl/lpr_pkg.sv
package lpr_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_ADDR_W-1:0] REG_SURFACE_WIDTH = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RED_POS       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GREEN_POS     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BLUE_POS      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA_POS     = 3'd4;

    localparam logic [6:0] SURFACE_WIDTH_RST = 7'd64;
    localparam logic [1:0] RED_POS_RST       = 2'd0;
    localparam logic [1:0] GREEN_POS_RST     = 2'd1;
    localparam logic [1:0] BLUE_POS_RST      = 2'd2;
    localparam logic [1:0] ALPHA_POS_RST     = 2'd3;

    // pixel limit per line and the width of the pixel counter
    localparam int OUT_LIMIT = 64;
    localparam int CNT_W     = $clog2(OUT_LIMIT + 1);

    localparam int WORD_W = 32;

    // command queue between front and walker
    localparam int FIFO_DEPTH = 2;
    localparam int LEVEL_W    = $clog2(FIFO_DEPTH + 1);

    // line class decided by the front
    typedef struct packed {
        logic x_major;
        logic y_down;
    } lpr_dir_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               full;
        logic               empty;
    } lpr_fifo_stat_t;

    typedef struct packed {
        logic busy;
        logic take;
    } lpr_walk_stat_t;

endpackage

FILE: hw/rtl/lpr_front.sv
module lpr_front #(
    parameter int COORD_BITS = 6,
    parameter int CMD_W      = 4 * COORD_BITS + 2 + lpr_pkg::CNT_W + lpr_pkg::WORD_W
) (
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [7:0]            alpha,
    input  logic [1:0]            red_pos,
    input  logic [1:0]            green_pos,
    input  logic [1:0]            blue_pos,
    input  logic [1:0]            alpha_pos,
    input  logic                  in_valid,
    input  logic                  queue_full,
    output logic                  in_ready,
    output logic                  push,
    output logic [CMD_W-1:0]      cmd
);

    localparam int CAP_W = (COORD_BITS > lpr_pkg::CNT_W) ? COORD_BITS : lpr_pkg::CNT_W;

    logic [COORD_BITS-1:0]     sx, sy, ex, ey, adx, ady, major;
    logic [CAP_W-1:0]          major_ext;
    logic [lpr_pkg::CNT_W-1:0] count;
    logic                      swap;
    lpr_pkg::lpr_dir_t         dir;
    logic [lpr_pkg::WORD_W-1:0] word;

    // handshake: take a command whenever the queue has room
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // canonical start: smaller x, or smaller y on a vertical line
    always_comb begin
        swap = (end_x < start_x) || ((end_x == start_x) && (end_y < start_y));
        sx   = swap ? end_x   : start_x;
        sy   = swap ? end_y   : start_y;
        ex   = swap ? start_x : end_x;
        ey   = swap ? start_y : end_y;
    end

    // deltas and line class
    always_comb begin
        adx         = ex - sx;
        ady         = (ey < sy) ? (sy - ey) : (ey - sy);
        dir.x_major = adx > ady;
        dir.y_down  = ey < sy;
        major       = dir.x_major ? adx : ady;
        major_ext   = CAP_W'(major);
        if (major == '0) begin
            count = lpr_pkg::CNT_W'(1);
        end else if (major_ext > CAP_W'(lpr_pkg::OUT_LIMIT)) begin
            count = lpr_pkg::CNT_W'(lpr_pkg::OUT_LIMIT);
        end else begin
            count = major_ext[lpr_pkg::CNT_W-1:0];
        end
    end

    // pixel word, later channels win on a shared lane
    always_comb begin
        word                  = '0;
        word[8*red_pos +: 8]   = red;
        word[8*green_pos +: 8] = green;
        word[8*blue_pos +: 8]  = blue;
        word[8*alpha_pos +: 8] = alpha;
    end

    assign cmd = {word, count, dir, ady, adx, sy, sx};

endmodule

FILE: hw/rtl/lpr_cmd_fifo.sv
module lpr_cmd_fifo #(
    parameter int CMD_W = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  logic [CMD_W-1:0]        din,
    input  logic                    pop,
    output logic [CMD_W-1:0]        dout,
    output lpr_pkg::lpr_fifo_stat_t stat
);

    localparam int PTR_W = $clog2(lpr_pkg::FIFO_DEPTH);

    logic [CMD_W-1:0]           mem [lpr_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg, rd_ptr_reg;
    logic [lpr_pkg::LEVEL_W-1:0] level_reg, level_next;

    // pointers and fill level
    always_comb begin
        level_next = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            level_reg <= level_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(lpr_pkg::FIFO_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(lpr_pkg::FIFO_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    assign dout       = mem[rd_ptr_reg];
    assign stat.level = level_reg;
    assign stat.full  = level_reg == lpr_pkg::LEVEL_W'(lpr_pkg::FIFO_DEPTH);
    assign stat.empty = level_reg == '0;

endmodule

FILE: hw/rtl/lpr_walker.sv
module lpr_walker #(
    parameter int COORD_BITS = 6,
    parameter int CMD_W      = 4 * COORD_BITS + 2 + lpr_pkg::CNT_W + lpr_pkg::WORD_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [6:0]                    surface_width,
    input  logic                          cmd_valid,
    input  logic [CMD_W-1:0]              cmd,
    output lpr_pkg::lpr_walk_stat_t       stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [COORD_BITS-1:0]         pixel_x,
    output logic [COORD_BITS-1:0]         pixel_y,
    output logic [2*COORD_BITS-1:0]       pixel_address,
    output logic [lpr_pkg::WORD_W-1:0]    pixel_word,
    output logic                          last_pixel
);

    localparam int EW = COORD_BITS + 3;
    localparam int AW = 2 * COORD_BITS;

    // command fields
    logic [COORD_BITS-1:0]      c_sx, c_sy, c_adx, c_ady;
    lpr_pkg::lpr_dir_t          c_dir;
    logic [lpr_pkg::CNT_W-1:0]  c_count;
    logic [lpr_pkg::WORD_W-1:0] c_word;

    // walk state
    logic                       busy_reg;
    logic [COORD_BITS-1:0]      x_reg, y_reg, adx_reg, ady_reg;
    logic signed [EW-1:0]       e_reg;
    lpr_pkg::lpr_dir_t          dir_reg;
    logic [lpr_pkg::CNT_W-1:0]  rem_reg;
    logic [lpr_pkg::WORD_W-1:0] word_reg;

    // output register
    logic                       out_valid_reg;
    logic [COORD_BITS-1:0]      px_reg, py_reg;
    logic [AW-1:0]              addr_reg;
    logic [lpr_pkg::WORD_W-1:0] pword_reg;
    logic                       last_reg;

    logic                       advance, take;
    logic signed [EW-1:0]       major_s, minor_s, e_inc, e_next;
    logic                       bump;
    logic [COORD_BITS-1:0]      x_next, y_next;
    logic [AW-1:0]              addr_next;

    assign {c_word, c_count, c_dir, c_ady, c_adx, c_sy, c_sx} = cmd;

    assign take    = !busy_reg && cmd_valid;
    assign advance = busy_reg && (!out_valid_reg || out_ready);

    // one error-term step
    always_comb begin
        major_s = dir_reg.x_major ? $signed(EW'(adx_reg)) : $signed(EW'(ady_reg));
        minor_s = dir_reg.x_major ? $signed(EW'(ady_reg)) : $signed(EW'(adx_reg));
        e_inc   = e_reg + minor_s;
        bump    = (e_inc <<< 1) > major_s;
        e_next  = bump ? (e_inc - major_s) : e_inc;
        if (dir_reg.x_major) begin
            x_next = x_reg + 1'b1;
            y_next = bump ? (dir_reg.y_down ? y_reg - 1'b1 : y_reg + 1'b1) : y_reg;
        end else begin
            x_next = bump ? x_reg + 1'b1 : x_reg;
            y_next = dir_reg.y_down ? y_reg - 1'b1 : y_reg + 1'b1;
        end
    end

    // linear address, wraps at the address width
    assign addr_next = AW'(AW'(surface_width) * AW'(y_reg)) + AW'(x_reg);

    // walker control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (take) begin
            busy_reg <= 1'b1;
        end else if (advance && (rem_reg == lpr_pkg::CNT_W'(1))) begin
            busy_reg <= 1'b0;
        end
    end

    // walk datapath
    always_ff @(posedge aclk) begin
        if (take) begin
            x_reg    <= c_sx;
            y_reg    <= c_sy;
            adx_reg  <= c_adx;
            ady_reg  <= c_ady;
            dir_reg  <= c_dir;
            rem_reg  <= c_count;
            word_reg <= c_word;
            e_reg    <= '0;
        end else if (advance) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            e_reg   <= e_next;
            rem_reg <= rem_reg - 1'b1;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            px_reg    <= x_reg;
            py_reg    <= y_reg;
            addr_reg  <= addr_next;
            pword_reg <= word_reg;
            last_reg  <= rem_reg == lpr_pkg::CNT_W'(1);
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.take     = take;
    assign out_valid     = out_valid_reg;
    assign pixel_x       = px_reg;
    assign pixel_y       = py_reg;
    assign pixel_address = addr_reg;
    assign pixel_word    = pword_reg;
    assign last_pixel    = last_reg;

endmodule

FILE: hw/rtl/line_pixel_rasterizer_top.sv
// Line rasterizer: each s_ transfer is one line command (two endpoints and an
// RGBA color); the block returns the line's pixels on m_, one per transfer, in
// walk order, with tlast on the final pixel. A line gives max(|dx|,|dy|) pixels
// (one for a point, at most 64). The walker produces one pixel per cycle when
// m_tready does not stall it, and it loads the next command from the two-entry
// command queue only after the last pixel of its line; the front accepts
// commands while the queue has room, so up to two lines can wait behind the one
// being walked. Configuration writes are meant for idle periods only.
module line_pixel_rasterizer_top #(
    parameter int COORD_BITS = 6
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write port
    input  logic                            cfg_wr_en,
    input  logic [lpr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lpr_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // line commands
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // start_x, start_y, end_x, end_y, red, green, blue, alpha, zero pad
    input  logic [((4*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
    // pixels
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_x, pixel_y, pixel_address, pixel_word, zero pad
    output logic [((4*COORD_BITS+32+7)/8)*8-1:0] m_tdata,
    output logic                            m_tlast
);

    localparam int C     = COORD_BITS;
    localparam int DW    = ((4 * C + 32 + 7) / 8) * 8;
    localparam int CMD_W = 4 * C + 2 + lpr_pkg::CNT_W + lpr_pkg::WORD_W;

    logic [6:0] surface_width_reg;
    logic [1:0] red_pos_reg, green_pos_reg, blue_pos_reg, alpha_pos_reg;

    logic                           push, queue_full;
    logic [CMD_W-1:0]               cmd_in, cmd_out;
    lpr_pkg::lpr_fifo_stat_t        fifo_stat;
    lpr_pkg::lpr_walk_stat_t        walk_stat;

    logic [C-1:0]                   pixel_x, pixel_y;
    logic [2*C-1:0]                 pixel_address;
    logic [lpr_pkg::WORD_W-1:0]     pixel_word;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            surface_width_reg <= lpr_pkg::SURFACE_WIDTH_RST;
            red_pos_reg       <= lpr_pkg::RED_POS_RST;
            green_pos_reg     <= lpr_pkg::GREEN_POS_RST;
            blue_pos_reg      <= lpr_pkg::BLUE_POS_RST;
            alpha_pos_reg     <= lpr_pkg::ALPHA_POS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lpr_pkg::REG_SURFACE_WIDTH: surface_width_reg <= cfg_wr_data;
                lpr_pkg::REG_RED_POS:       red_pos_reg       <= cfg_wr_data[1:0];
                lpr_pkg::REG_GREEN_POS:     green_pos_reg     <= cfg_wr_data[1:0];
                lpr_pkg::REG_BLUE_POS:      blue_pos_reg      <= cfg_wr_data[1:0];
                lpr_pkg::REG_ALPHA_POS:     alpha_pos_reg     <= cfg_wr_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign queue_full = fifo_stat.full;

    // front: accept and classify
    lpr_front #(
        .COORD_BITS (C),
        .CMD_W      (CMD_W)
    ) u_front (
        .start_x    (s_tdata[C-1:0]),
        .start_y    (s_tdata[2*C-1:C]),
        .end_x      (s_tdata[3*C-1:2*C]),
        .end_y      (s_tdata[4*C-1:3*C]),
        .red        (s_tdata[4*C+7:4*C]),
        .green      (s_tdata[4*C+15:4*C+8]),
        .blue       (s_tdata[4*C+23:4*C+16]),
        .alpha      (s_tdata[4*C+31:4*C+24]),
        .red_pos    (red_pos_reg),
        .green_pos  (green_pos_reg),
        .blue_pos   (blue_pos_reg),
        .alpha_pos  (alpha_pos_reg),
        .in_valid   (s_tvalid),
        .queue_full (queue_full),
        .in_ready   (s_tready),
        .push       (push),
        .cmd        (cmd_in)
    );

    // command queue
    lpr_cmd_fifo #(
        .CMD_W   (CMD_W)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (cmd_in),
        .pop     (walk_stat.take),
        .dout    (cmd_out),
        .stat    (fifo_stat)
    );

    // back: line walk
    lpr_walker #(
        .COORD_BITS    (C),
        .CMD_W         (CMD_W)
    ) u_walker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .surface_width (surface_width_reg),
        .cmd_valid     (!fifo_stat.empty),
        .cmd           (cmd_out),
        .stat          (walk_stat),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_word    (pixel_word),
        .last_pixel    (m_tlast)
    );

    assign m_tdata = DW'({pixel_word, pixel_address, pixel_y, pixel_x});

    // reset empties the output stage
    a_reset_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // queue level stays within depth and matches the full flag
    a_fifo_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (fifo_stat.level <= lpr_pkg::LEVEL_W'(lpr_pkg::FIFO_DEPTH)) &&
        (fifo_stat.full == (fifo_stat.level == lpr_pkg::LEVEL_W'(lpr_pkg::FIFO_DEPTH))))
        else $error("command queue level out of range");

    // a pixel that is not the last one leaves the walker busy on its line
    a_mid_line_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> walk_stat.busy)
        else $error("walker idle in the middle of a line");

    // the walker only loads a command that the queue holds
    a_take_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_stat.take |=> (walk_stat.busy && $past(fifo_stat.level) != '0))
        else $error("walker loaded from an empty queue");

endmodule
